### rtl/tdc_pkg.sv
package tdc_pkg;

   localparam int unsigned SETPOINT_W  = 7;
   localparam int unsigned STEP_W      = 4;
   localparam int unsigned DEADBAND_W  = 5;
   localparam int unsigned TIMEOUT_W   = 4;
   localparam int unsigned STORED_W    = 8;
   localparam int unsigned DISPLAY_W   = 9;
   localparam int unsigned KIND_W      = 2;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 7;
   localparam int unsigned RSP_TDATA_W = 24;

   localparam int unsigned IDLE_MAX    = 15;
   localparam int unsigned DISPLAY_MAX = 511;
   localparam int unsigned AVG_SCALE   = 500;

   localparam logic [SETPOINT_W-1:0] RESET_MIN      = 7'd35;
   localparam logic [SETPOINT_W-1:0] RESET_MAX      = 7'd75;
   localparam logic [SETPOINT_W-1:0] RESET_DEFAULT  = 7'd60;
   localparam logic [STEP_W-1:0]     RESET_STEP     = 4'd5;
   localparam logic [DEADBAND_W-1:0] RESET_DEADBAND = 5'd5;
   localparam logic [TIMEOUT_W-1:0]  RESET_TIMEOUT  = 4'd5;
   localparam logic [SETPOINT_W-1:0] RESET_TARGET   = 7'd60;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SETPOINT_MIN     = 3'd0,
      REG_SETPOINT_MAX     = 3'd1,
      REG_SETPOINT_DEFAULT = 3'd2,
      REG_SETPOINT_STEP    = 3'd3,
      REG_DEADBAND         = 3'd4,
      REG_TIMEOUT_TICKS    = 3'd5
   } reg_index_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_POWER  = 2'd0,
      KIND_BUTTON = 2'd1,
      KIND_ADC    = 2'd2,
      KIND_TICK   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [SETPOINT_W-1:0] setpoint_min;
      logic [SETPOINT_W-1:0] setpoint_max;
      logic [SETPOINT_W-1:0] setpoint_default;
      logic [STEP_W-1:0]     setpoint_step;
      logic [DEADBAND_W-1:0] deadband;
      logic [TIMEOUT_W-1:0]  timeout_ticks;
   } cfg_type;

   // state after one transaction, as needed by the later stages
   typedef struct packed {
      logic                  powered;
      logic                  adjusting;
      logic                  blank;
      logic                  save;
      logic                  clear_run;
      logic                  tick;
      logic [SETPOINT_W-1:0] target;
   } snap_type;

   function automatic int unsigned full_scale(int unsigned adc_bits);
      return (32'd1 << adc_bits) - 32'd1;
   endfunction

   function automatic int unsigned sum_width(int unsigned adc_bits, int unsigned samples);
      return $clog2(full_scale(adc_bits) * samples + 1);
   endfunction

   function automatic int unsigned frac_shift(int unsigned adc_bits, int unsigned samples);
      return sum_width(adc_bits, samples) + $clog2(full_scale(adc_bits) * samples + 1);
   endfunction

   function automatic int unsigned recip_width(int unsigned adc_bits, int unsigned samples);
      return sum_width(adc_bits, samples) + 11;
   endfunction

endpackage

### rtl/tdc_cfg_regs.sv
module tdc_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tdc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [tdc_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output tdc_pkg::cfg_type                    cfg
);

   tdc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (tdc_pkg::reg_index_type'(csr_addr))
            tdc_pkg::REG_SETPOINT_MIN:     cfg_in.setpoint_min     = csr_wr_data;
            tdc_pkg::REG_SETPOINT_MAX:     cfg_in.setpoint_max     = csr_wr_data;
            tdc_pkg::REG_SETPOINT_DEFAULT: cfg_in.setpoint_default = csr_wr_data;
            tdc_pkg::REG_SETPOINT_STEP:    cfg_in.setpoint_step    = csr_wr_data[3:0];
            tdc_pkg::REG_DEADBAND:         cfg_in.deadband         = csr_wr_data[4:0];
            tdc_pkg::REG_TIMEOUT_TICKS:    cfg_in.timeout_ticks    = csr_wr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint_min     <= tdc_pkg::RESET_MIN;
         cfg_ff.setpoint_max     <= tdc_pkg::RESET_MAX;
         cfg_ff.setpoint_default <= tdc_pkg::RESET_DEFAULT;
         cfg_ff.setpoint_step    <= tdc_pkg::RESET_STEP;
         cfg_ff.deadband         <= tdc_pkg::RESET_DEADBAND;
         cfg_ff.timeout_ticks    <= tdc_pkg::RESET_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/tdc_state_update.sv
module tdc_state_update #(
   parameter int unsigned SAMPLES_PER_AVERAGE = 10,
   parameter int unsigned ADC_BITS = 10,
   localparam int unsigned SUM_W = tdc_pkg::sum_width(ADC_BITS, SAMPLES_PER_AVERAGE)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tdc_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  tdc_pkg::kind_type                 in_kind,
   input  logic                              in_up,
   input  logic                              in_down,
   input  logic [ADC_BITS-1:0]               in_sample,
   input  logic [tdc_pkg::STORED_W-1:0]      in_stored,
   output logic                              out_valid,
   input  logic                              out_ready,
   output tdc_pkg::snap_type                 out_snap,
   output logic [SUM_W-1:0]                  out_sum
);

   localparam int unsigned IDX_W = $clog2(SAMPLES_PER_AVERAGE + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_AVERAGE - 1);
   localparam int unsigned SP_W = tdc_pkg::SETPOINT_W;

   // input register
   logic                          in_valid_ff;
   tdc_pkg::kind_type             kind_ff;
   logic                          up_ff, down_ff;
   logic [ADC_BITS-1:0]           sample_ff;
   logic [tdc_pkg::STORED_W-1:0]  stored_ff;

   // controller state
   logic                          powered_ff, powered_in;
   logic                          adjusting_ff, adjusting_in;
   logic [SP_W-1:0]               target_ff, target_in;
   logic [tdc_pkg::TIMEOUT_W-1:0] idle_ff, idle_in;
   logic [SUM_W-1:0]              run_sum_ff, run_sum_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic [SUM_W-1:0]              latched_ff, latched_in;
   logic                          blank_ff, blank_in;

   logic                          out_valid_ff, out_valid_in;
   tdc_pkg::snap_type             snap_ff, snap_in;
   logic [SUM_W-1:0]              out_sum_ff;

   logic                          take;
   logic                          save_in;
   logic                          btn_adj;
   logic [SUM_W-1:0]              sum_next;
   logic [SP_W:0]                 target_up;
   logic [SP_W:0]                 down_floor;
   logic [tdc_pkg::TIMEOUT_W-1:0] idle_inc;

   assign take     = in_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !in_valid_ff || take;

   always_comb begin
      powered_in   = powered_ff;
      adjusting_in = adjusting_ff;
      target_in    = target_ff;
      idle_in      = idle_ff;
      run_sum_in   = run_sum_ff;
      idx_in       = idx_ff;
      latched_in   = latched_ff;
      blank_in     = blank_ff;
      save_in      = 1'b0;

      sum_next   = run_sum_ff + SUM_W'(sample_ff);
      target_up  = {1'b0, target_ff} + {4'b0000, cfg.setpoint_step};
      down_floor = {1'b0, cfg.setpoint_min} + {4'b0000, cfg.setpoint_step};
      idle_inc   = (idle_ff < 4'(tdc_pkg::IDLE_MAX)) ? idle_ff + 4'd1 : idle_ff;
      btn_adj    = adjusting_ff || up_ff || down_ff;

      if (take) begin
         unique case (kind_ff)
            tdc_pkg::KIND_POWER: begin
               if (!powered_ff) begin
                  if (stored_ff < {1'b0, cfg.setpoint_min} ||
                      stored_ff > {1'b0, cfg.setpoint_max}) begin
                     target_in = cfg.setpoint_default;
                  end else begin
                     target_in = stored_ff[SP_W-1:0];
                  end
               end else begin
                  save_in = 1'b1;
               end
               powered_in   = !powered_ff;
               adjusting_in = 1'b0;
               idle_in      = '0;
               blank_in     = 1'b0;
               run_sum_in   = '0;
               idx_in       = '0;
            end
            tdc_pkg::KIND_BUTTON: begin
               if (powered_ff) begin
                  if (btn_adj && idle_ff < cfg.timeout_ticks) begin
                     adjusting_in = 1'b1;
                     if (up_ff) begin
                        if (target_ff < cfg.setpoint_max) begin
                           target_in = (target_up > {1'b0, cfg.setpoint_max}) ?
                                       cfg.setpoint_max : target_up[SP_W-1:0];
                        end
                        idle_in = '0;
                     end else if (down_ff) begin
                        if (target_ff > cfg.setpoint_min) begin
                           target_in = ({1'b0, target_ff} < down_floor) ?
                                       cfg.setpoint_min :
                                       target_ff - {3'b000, cfg.setpoint_step};
                        end
                        idle_in = '0;
                     end
                  end else if (btn_adj) begin
                     adjusting_in = 1'b0;
                     idle_in      = '0;
                     blank_in     = 1'b0;
                  end
               end
            end
            tdc_pkg::KIND_ADC: begin
               if (powered_ff) begin
                  if (idx_ff == IDX_LAST) begin
                     latched_in = sum_next;
                     run_sum_in = '0;
                     idx_in     = '0;
                  end else begin
                     run_sum_in = sum_next;
                     idx_in     = idx_ff + IDX_W'(1);
                  end
               end
            end
            tdc_pkg::KIND_TICK: begin
               if (powered_ff && adjusting_ff) begin
                  if (idle_inc >= cfg.timeout_ticks) begin
                     adjusting_in = 1'b0;
                     idle_in      = '0;
                     blank_in     = 1'b0;
                  end else begin
                     idle_in  = idle_inc;
                     blank_in = !blank_ff;
                  end
               end
            end
         endcase
      end

      snap_in.powered   = powered_in;
      snap_in.adjusting = adjusting_in;
      snap_in.blank     = blank_in;
      snap_in.save      = save_in;
      snap_in.clear_run = (kind_ff == tdc_pkg::KIND_POWER);
      snap_in.tick      = (kind_ff == tdc_pkg::KIND_TICK) && powered_ff;
      snap_in.target    = target_in;

      out_valid_in = take || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         powered_ff   <= 1'b0;
         adjusting_ff <= 1'b0;
         target_ff    <= tdc_pkg::RESET_TARGET;
         idle_ff      <= '0;
         run_sum_ff   <= '0;
         idx_ff       <= '0;
         latched_ff   <= '0;
         blank_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid || (in_valid_ff && !take);
         powered_ff   <= powered_in;
         adjusting_ff <= adjusting_in;
         target_ff    <= target_in;
         idle_ff      <= idle_in;
         run_sum_ff   <= run_sum_in;
         idx_ff       <= idx_in;
         latched_ff   <= latched_in;
         blank_ff     <= blank_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         kind_ff   <= in_kind;
         up_ff     <= in_up;
         down_ff   <= in_down;
         sample_ff <= in_sample;
         stored_ff <= in_stored;
      end
      if (take) begin
         snap_ff    <= snap_in;
         out_sum_ff <= latched_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_snap  = snap_ff;
   assign out_sum   = out_sum_ff;

endmodule

### rtl/tdc_average.sv
module tdc_average #(
   parameter int unsigned SAMPLES_PER_AVERAGE = 10,
   parameter int unsigned ADC_BITS = 10,
   localparam int unsigned SUM_W = tdc_pkg::sum_width(ADC_BITS, SAMPLES_PER_AVERAGE),
   localparam int unsigned PROD_W = SUM_W + tdc_pkg::recip_width(ADC_BITS, SAMPLES_PER_AVERAGE)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tdc_pkg::snap_type    in_snap,
   input  logic [SUM_W-1:0]     in_sum,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tdc_pkg::snap_type    out_snap,
   output logic [PROD_W-1:0]    out_prod
);

   localparam int unsigned RECIP_W = tdc_pkg::recip_width(ADC_BITS, SAMPLES_PER_AVERAGE);
   localparam int unsigned FRAC_S  = tdc_pkg::frac_shift(ADC_BITS, SAMPLES_PER_AVERAGE);
   localparam logic [63:0] DIVISOR =
      64'(tdc_pkg::full_scale(ADC_BITS)) * 64'(SAMPLES_PER_AVERAGE);
   // ceil(500 * 2^FRAC_S / DIVISOR): floor of the product is the exact average
   localparam logic [63:0] RECIP64 =
      ((64'(tdc_pkg::AVG_SCALE) << FRAC_S) + DIVISOR - 64'd1) / DIVISOR;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

   logic                valid_ff;
   tdc_pkg::snap_type   snap_ff;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign prod_in  = PROD_W'(in_sum) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= take || (valid_ff && !out_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         snap_ff <= in_snap;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_snap  = snap_ff;
   assign out_prod  = prod_ff;

endmodule

### rtl/tdc_control_out.sv
module tdc_control_out #(
   parameter int unsigned SAMPLES_PER_AVERAGE = 10,
   parameter int unsigned ADC_BITS = 10,
   localparam int unsigned SUM_W = tdc_pkg::sum_width(ADC_BITS, SAMPLES_PER_AVERAGE),
   localparam int unsigned PROD_W = SUM_W + tdc_pkg::recip_width(ADC_BITS, SAMPLES_PER_AVERAGE)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [tdc_pkg::DEADBAND_W-1:0]        deadband,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  tdc_pkg::snap_type                     in_snap,
   input  logic [PROD_W-1:0]                     in_prod,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tdc_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   localparam int unsigned FRAC_S = tdc_pkg::frac_shift(ADC_BITS, SAMPLES_PER_AVERAGE);
   localparam int unsigned HI_W   = PROD_W - FRAC_S;
   localparam int unsigned DISP_W = tdc_pkg::DISPLAY_W;
   localparam logic [63:0] DIVISOR =
      64'(tdc_pkg::full_scale(ADC_BITS)) * 64'(SAMPLES_PER_AVERAGE);
   // fraction bits at or above this mean the average is not a whole number
   localparam logic [FRAC_S-1:0] FRAC_T =
      FRAC_S'(((64'd1 << FRAC_S) + DIVISOR - 64'd1) / DIVISOR);

   logic                                heating_ff, cooling_ff, led_ff;
   logic                                heat_in, cool_in, led_in;
   logic                                rsp_valid_ff;
   logic [tdc_pkg::RSP_TDATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                                take;
   logic [HI_W-1:0]                     avg_hi;
   logic [DISP_W-1:0]                   avg;
   logic                                frac_nz;
   logic [DISP_W-1:0]                   t9, d9, band_lo, band_hi;
   logic [DISP_W-1:0]                   disp_value;
   logic                                pw;

   assign in_ready = !rsp_valid_ff || rsp_tready;
   assign take     = in_valid && in_ready;

   always_comb begin
      avg_hi  = in_prod[PROD_W-1:FRAC_S];
      avg     = (avg_hi > HI_W'(tdc_pkg::DISPLAY_MAX)) ?
                DISP_W'(tdc_pkg::DISPLAY_MAX) : avg_hi[DISP_W-1:0];
      frac_nz = (in_prod[FRAC_S-1:0] >= FRAC_T);
      pw      = in_snap.powered;

      t9      = DISP_W'(in_snap.target);
      d9      = DISP_W'(deadband);
      band_lo = t9 - d9;
      band_hi = t9 + d9;

      heat_in = pw && (t9 >= d9) && (avg < band_lo);
      cool_in = pw && !heat_in && ((avg > band_hi) || ((avg == band_hi) && frac_nz));

      led_in = led_ff;
      if (in_snap.clear_run) begin
         led_in = 1'b0;
      end else if (in_snap.tick) begin
         if (cooling_ff) begin
            led_in = 1'b1;
         end else if (heating_ff) begin
            led_in = !led_ff;
         end
      end

      disp_value = in_snap.adjusting ? t9 : avg;

      rsp_data_in = {1'b0,
                     in_snap.target,
                     in_snap.save,
                     pw && in_snap.adjusting,
                     pw ? disp_value : {DISP_W{1'b0}},
                     pw && !(in_snap.adjusting && in_snap.blank),
                     pw && led_in,
                     pw,
                     cool_in,
                     heat_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heating_ff   <= 1'b0;
         cooling_ff   <= 1'b0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            heating_ff <= heat_in;
            cooling_ff <= cool_in;
            led_ff     <= led_in;
         end
         rsp_valid_ff <= take || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/thermostat_deadband_controller_core.sv
// Heater/cooler thermostat with deadband, one result transaction per request transaction.
// req channel: tuser = kind (power press, button sample, adc sample, tick);
//   tdata carries the buttons, the ADC conversion and the stored setpoint byte.
// rsp channel: relay drives, LEDs, display enable and value, setting mode,
//   save request and the setpoint to save.
// csr port: single-cycle register writes, only while no transaction is in flight; the
// user must keep to this, the block does not check it. Pipeline: input register, state
// update, average multiply, control/output register; rsp_tvalid comes from the last.
// Throughput is one transaction per clock unless the rsp side stalls. Controller state
// updates happen in the single state-update stage (LED and relay state in the output
// stage), so back-to-back requests see each other's results. The average uses one
// constant-reciprocal multiply, registered before the deadband compares.
// Each stage holds while the stage after it is full, so a stalled rsp side
// fills the pipeline bubbles first and then drops req_tready.
// Reset clears all valids, switches the controller off, loads the default
// register values and sets the setpoint to 60.
module thermostat_deadband_controller_core #(
   parameter int unsigned SAMPLES_PER_AVERAGE = 10,
   parameter int unsigned ADC_BITS = 10,
   localparam int unsigned REQ_TDATA_W = ((ADC_BITS + 10 + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // up_pressed, down_pressed, adc_sample, stored_setpoint
   input  logic [REQ_TDATA_W-1:0]                req_tdata,
   // req_type
   input  logic [tdc_pkg::KIND_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // heater_on, cooler_on, power_led, status_led, display_on, display_value,
   // setting_active, save_request, save_value
   output logic [tdc_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [tdc_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [tdc_pkg::CSR_DATA_W-1:0]        csr_wr_data
);

   localparam int unsigned SUM_W  = tdc_pkg::sum_width(ADC_BITS, SAMPLES_PER_AVERAGE);
   localparam int unsigned PROD_W = SUM_W + tdc_pkg::recip_width(ADC_BITS, SAMPLES_PER_AVERAGE);

   tdc_pkg::cfg_type                 cfg;
   logic                             s1_valid, s1_ready;
   tdc_pkg::snap_type                s1_snap;
   logic [SUM_W-1:0]                 s1_sum;
   logic                             s2_valid, s2_ready;
   tdc_pkg::snap_type                s2_snap;
   logic [PROD_W-1:0]                s2_prod;

   tdc_cfg_regs u_cfg (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   tdc_state_update #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
      .ADC_BITS            (ADC_BITS)
   ) u_state (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (tdc_pkg::kind_type'(req_tuser)),
      .in_up     (req_tdata[0]),
      .in_down   (req_tdata[1]),
      .in_sample (req_tdata[ADC_BITS+1:2]),
      .in_stored (req_tdata[ADC_BITS+9:ADC_BITS+2]),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_snap  (s1_snap),
      .out_sum   (s1_sum)
   );

   tdc_average #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
      .ADC_BITS            (ADC_BITS)
   ) u_avg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_snap   (s1_snap),
      .in_sum    (s1_sum),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_snap  (s2_snap),
      .out_prod  (s2_prod)
   );

   tdc_control_out #(
      .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE),
      .ADC_BITS            (ADC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .deadband   (cfg.deadband),
      .in_valid   (s2_valid),
      .in_ready   (s2_ready),
      .in_snap    (s2_snap),
      .in_prod    (s2_prod),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### verif/thermostat_deadband_controller_core_tb.sv
module thermostat_deadband_controller_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdc_pkg::*;

   localparam int SAMPLES     = 10;
   localparam int ADC_BITS    = 10;
   localparam int ADC_FULL    = (1 << ADC_BITS) - 1;
   localparam int REQ_W       = ((ADC_BITS + 10 + 7) / 8) * 8;
   localparam int QUIET_LIMIT = 4000;
   localparam int PIPE_DRAIN  = 6;
   localparam int BLOCK_ITEMS = 240;

   // index outside the register map, must be ignored
   localparam logic [CSR_ADDR_W-1:0] REG_NONE = 3'd7;

   typedef struct packed {
      logic                  spare;
      logic [SETPOINT_W-1:0] save_value;
      logic                  save_request;
      logic                  setting_active;
      logic [DISPLAY_W-1:0]  display_value;
      logic                  display_on;
      logic                  status_led;
      logic                  power_led;
      logic                  cooler_on;
      logic                  heater_on;
   } readout_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata;
   logic [KIND_W-1:0]       req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_wr_en;
   logic [CSR_ADDR_W-1:0]   csr_addr;
   logic [CSR_DATA_W-1:0]   csr_wr_data;

   thermostat_deadband_controller_core #(
      .SAMPLES_PER_AVERAGE(SAMPLES),
      .ADC_BITS(ADC_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en),
      .csr_addr(csr_addr),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted thermostat state and register copy
   cfg_type               cfg;
   logic                  is_on, in_setting, heat, cool, led_blink, blank;
   logic [SETPOINT_W-1:0] setpoint;
   logic [TIMEOUT_W-1:0]  quiet_ticks;
   int unsigned           acc_sum, acc_count, avg_sum;

   readout_type pending_readouts[$];
   int unsigned mismatches = 0;
   int unsigned live_items = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   function automatic void advance_thermostat(kind_type kind, logic up, logic down,
                                              logic [9:0] sample, logic [7:0] stored);
      readout_type r;
      int unsigned lhs, scale, avg, raised;
      logic        save;
      save  = 1'b0;
      scale = ADC_FULL * SAMPLES;
      if (kind == KIND_POWER) begin
         if (!is_on) begin
            if (stored < 8'(cfg.setpoint_min) || stored > 8'(cfg.setpoint_max))
               setpoint = cfg.setpoint_default;
            else
               setpoint = stored[SETPOINT_W-1:0];
            is_on = 1'b1;
         end else begin
            save  = 1'b1;
            is_on = 1'b0;
         end
         in_setting = 1'b0; quiet_ticks = '0; heat = 1'b0; cool = 1'b0;
         led_blink = 1'b0; blank = 1'b0; acc_sum = 0; acc_count = 0;
      end else if (is_on) begin
         case (kind)
            KIND_BUTTON: begin
               if ((up || down) && !in_setting)
                  in_setting = 1'b1;
               if (in_setting && quiet_ticks < cfg.timeout_ticks) begin
                  if (up) begin
                     if (setpoint < cfg.setpoint_max) begin
                        raised = int'(setpoint) + int'(cfg.setpoint_step);
                        setpoint = (raised > 32'(cfg.setpoint_max)) ? cfg.setpoint_max
                                                                    : raised[SETPOINT_W-1:0];
                     end
                     quiet_ticks = '0;
                  end else if (down) begin
                     if (setpoint > cfg.setpoint_min) begin
                        if (int'(setpoint) < int'(cfg.setpoint_min) + int'(cfg.setpoint_step))
                           setpoint = cfg.setpoint_min;
                        else
                           setpoint = setpoint - SETPOINT_W'(cfg.setpoint_step);
                     end
                     quiet_ticks = '0;
                  end
               end else if (in_setting) begin
                  in_setting = 1'b0; quiet_ticks = '0; blank = 1'b0;
               end
            end
            KIND_ADC: begin
               acc_sum += 32'(sample);
               acc_count++;
               if (acc_count >= SAMPLES) begin
                  avg_sum = acc_sum; acc_sum = 0; acc_count = 0;
               end
            end
            default: begin
               if (in_setting) begin
                  if (32'(quiet_ticks) < IDLE_MAX)
                     quiet_ticks++;
                  blank = ~blank;
                  if (quiet_ticks >= cfg.timeout_ticks) begin
                     in_setting = 1'b0; quiet_ticks = '0; blank = 1'b0;
                  end
               end
               if (cool)
                  led_blink = 1'b1;
               else if (heat)
                  led_blink = ~led_blink;
            end
         endcase
      end

      lhs = avg_sum * AVG_SCALE;
      if (is_on) begin
         heat = 1'b0;
         cool = 1'b0;
         if (int'(setpoint) >= int'(cfg.deadband) &&
             lhs < (int'(setpoint) - int'(cfg.deadband)) * scale)
            heat = 1'b1;
         else if (lhs > (int'(setpoint) + int'(cfg.deadband)) * scale)
            cool = 1'b1;
      end

      r = '0;
      if (is_on) begin
         avg = lhs / scale;
         if (avg > DISPLAY_MAX)
            avg = DISPLAY_MAX;
         r.heater_on      = heat;
         r.cooler_on      = cool;
         r.power_led      = 1'b1;
         r.status_led     = led_blink;
         r.display_on     = !(in_setting && blank);
         r.display_value  = in_setting ? DISPLAY_W'(setpoint) : avg[DISPLAY_W-1:0];
         r.setting_active = in_setting;
      end
      r.save_request = save;
      r.save_value   = setpoint;
      pending_readouts.push_back(r);
   endfunction

   task automatic send_item(kind_type kind, logic up, logic down,
                            logic [9:0] sample, logic [7:0] stored);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, stored, sample, down, up};
      do
         @(posedge clock);
      while (!req_tready);
      if (kind == KIND_POWER || is_on)
         live_items++;
      advance_thermostat(kind, up, down, sample, stored);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_readouts.size() != 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_addr    <= addr;
      csr_wr_data <= value;
      @(posedge clock);
      case (addr)
         REG_SETPOINT_MIN:     cfg.setpoint_min     = value[SETPOINT_W-1:0];
         REG_SETPOINT_MAX:     cfg.setpoint_max     = value[SETPOINT_W-1:0];
         REG_SETPOINT_DEFAULT: cfg.setpoint_default = value[SETPOINT_W-1:0];
         REG_SETPOINT_STEP:    cfg.setpoint_step    = value[STEP_W-1:0];
         REG_DEADBAND:         cfg.deadband         = value[DEADBAND_W-1:0];
         REG_TIMEOUT_TICKS:    cfg.timeout_ticks    = value[TIMEOUT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(int unsigned which);
      logic [CSR_DATA_W-1:0] lo, hi, dflt, step, band, wait_t;
      case (which)
         // widest: min and default at zero, everything else at the top of its field
         1: {lo, hi, dflt, step, band, wait_t} = {7'd0, 7'h7F, 7'd0, 7'h7F, 7'h7F, 7'h7F};
         // single legal setpoint, no deadband, one-tick timeout
         2: {lo, hi, dflt, step, band, wait_t} = {7'd50, 7'd50, 7'd99, 7'd1, 7'd0, 7'd1};
         // inverted limits, zero step, zero timeout (upper bits masked off)
         3: {lo, hi, dflt, step, band, wait_t} = {7'd99, 7'd0, 7'h7F, 7'h10, 7'h20, 7'h30};
         default: begin
            if ($urandom_range(3) != 0) begin
               lo     = 7'($urandom_range(60));
               hi     = 7'($urandom_range(99, lo));
               dflt   = 7'($urandom_range(99));
               step   = 7'($urandom_range(15, 1));
               band   = 7'($urandom_range(31));
               wait_t = 7'($urandom_range(15, 1));
            end else begin
               lo     = 7'($urandom_range(127));
               hi     = 7'($urandom_range(127));
               dflt   = 7'($urandom_range(127));
               step   = 7'($urandom_range(127));
               band   = 7'($urandom_range(127));
               wait_t = 7'($urandom_range(127));
            end
         end
      endcase
      write_reg(REG_SETPOINT_MIN, lo);
      write_reg(REG_SETPOINT_MAX, hi);
      write_reg(REG_SETPOINT_DEFAULT, dflt);
      write_reg(REG_SETPOINT_STEP, step);
      write_reg(REG_DEADBAND, band);
      write_reg(REG_TIMEOUT_TICKS, wait_t);
      if (which == 1)
         write_reg(REG_NONE, 7'h55);
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_switched_off();
      send_item(KIND_BUTTON, 1'b1, 1'b1, 10'd0, 8'd0);
      send_item(KIND_ADC, 1'b0, 1'b0, 10'd1023, 8'd0);
   endtask

   task automatic test_setpoint_limits();
      send_item(KIND_POWER, 1'b0, 1'b0, 10'd0, 8'd255);
      send_item(KIND_BUTTON, 1'b1, 1'b1, 10'd0, 8'd0);
      send_item(KIND_POWER, 1'b0, 1'b0, 10'd0, 8'd0);
      send_item(KIND_POWER, 1'b0, 1'b0, 10'd0, 8'd72);
      send_item(KIND_BUTTON, 1'b1, 1'b0, 10'd0, 8'd0);
      send_item(KIND_BUTTON, 1'b1, 1'b0, 10'd0, 8'd0);
      send_item(KIND_POWER, 1'b0, 1'b0, 10'd0, 8'd0);
      send_item(KIND_POWER, 1'b0, 1'b0, 10'd0, 8'd36);
      send_item(KIND_BUTTON, 1'b0, 1'b1, 10'd0, 8'd0);
      send_item(KIND_BUTTON, 1'b0, 1'b1, 10'd0, 8'd0);
   endtask

   task automatic test_setting_timeout();
      repeat (5) send_item(KIND_TICK, 1'b0, 1'b0, 10'd0, 8'd0);
   endtask

   task automatic test_averaging();
      repeat (SAMPLES) send_item(KIND_ADC, 1'b0, 1'b0, 10'd1023, 8'd0);
      send_item(KIND_TICK, 1'b0, 1'b0, 10'd0, 8'd0);
   endtask

   task automatic test_random_traffic(int unsigned count);
      int unsigned goal, pick, mode, span;
      int          level;
      logic        up, down;
      logic [9:0]  sample;
      logic [7:0]  stored;
      goal = live_items + count;
      while (live_items < goal) begin
         pick = $urandom_range(99);
         if (!is_on) begin
            if (pick < 75) begin
               if (pick < 45 && cfg.setpoint_min <= cfg.setpoint_max)
                  stored = 8'($urandom_range(cfg.setpoint_max, cfg.setpoint_min));
               else
                  stored = 8'($urandom_range(255));
               send_item(KIND_POWER, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         10'($urandom_range(1023)), stored);
            end else begin
               send_item(kind_type'($urandom_range(3, 1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 10'($urandom_range(1023)),
                         8'($urandom_range(255)));
            end
         end else if (pick < 4) begin
            send_item(KIND_POWER, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      10'($urandom_range(1023)), 8'($urandom_range(255)));
         end else if (pick < 40) begin
            mode = $urandom_range(3);
            span = 32'(2 * int'(cfg.deadband) + 4);
            repeat (SAMPLES) begin
               case (mode)
                  0: sample = 10'($urandom_range(1023));
                  1: sample = $urandom_range(1) ? 10'd1023 : 10'd0;
                  default: begin
                     level = int'(setpoint) * ADC_FULL / int'(AVG_SCALE)
                             + int'($urandom_range(2 * span)) - int'(span);
                     if (level < 0)
                        level = 0;
                     if (level > ADC_FULL)
                        level = ADC_FULL;
                     sample = level[9:0];
                  end
               endcase
               send_item(KIND_ADC, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         sample, 8'($urandom_range(255)));
            end
         end else if (pick < 65) begin
            repeat ($urandom_range(6, 1)) begin
               mode = $urandom_range(9);
               up   = (mode < 4) || (mode == 8);
               down = (mode >= 4 && mode < 9);
               send_item(KIND_BUTTON, up, down, 10'($urandom_range(1023)),
                         8'($urandom_range(255)));
            end
         end else if (pick < 90) begin
            repeat ($urandom_range(18, 1))
               send_item(KIND_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         10'($urandom_range(1023)), 8'($urandom_range(255)));
         end else begin
            send_item(kind_type'($urandom_range(3)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 10'($urandom_range(1023)),
                      8'($urandom_range(255)));
         end
      end
   endtask

   task automatic report_field(string field, logic [15:0] want, logic [15:0] got);
      $display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_readouts
      readout_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = readout_type'(rsp_tdata);
            if (pending_readouts.size() == 0) begin
               $display("%0t unexpected result transaction: expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_readouts.pop_front();
               if (got.heater_on !== want.heater_on)
                  report_field("heater_on", 16'(want.heater_on), 16'(got.heater_on));
               if (got.cooler_on !== want.cooler_on)
                  report_field("cooler_on", 16'(want.cooler_on), 16'(got.cooler_on));
               if (got.power_led !== want.power_led)
                  report_field("power_led", 16'(want.power_led), 16'(got.power_led));
               if (got.status_led !== want.status_led)
                  report_field("status_led", 16'(want.status_led), 16'(got.status_led));
               if (got.display_on !== want.display_on)
                  report_field("display_on", 16'(want.display_on), 16'(got.display_on));
               if (got.display_value !== want.display_value)
                  report_field("display_value", 16'(want.display_value),
                               16'(got.display_value));
               if (got.setting_active !== want.setting_active)
                  report_field("setting_active", 16'(want.setting_active),
                               16'(got.setting_active));
               if (got.save_request !== want.save_request)
                  report_field("save_request", 16'(want.save_request),
                               16'(got.save_request));
               if (got.save_value !== want.save_value)
                  report_field("save_value", 16'(want.save_value), 16'(got.save_value));
            end
         end
         rsp_tready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", quiet_cycles);
            $display("thermostat_deadband_controller_core: mismatch");
            $finish;
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= KIND_POWER;
      csr_wr_en   <= 1'b0;
      csr_addr    <= '0;
      csr_wr_data <= '0;
      cfg = '{RESET_MIN, RESET_MAX, RESET_DEFAULT, RESET_STEP, RESET_DEADBAND, RESET_TIMEOUT};
      is_on = 1'b0; in_setting = 1'b0; heat = 1'b0; cool = 1'b0;
      led_blink = 1'b0; blank = 1'b0; setpoint = RESET_TARGET; quiet_ticks = '0;
      acc_sum = 0; acc_count = 0; avg_sum = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_switched_off();
      test_setpoint_limits();
      test_setting_timeout();
      test_averaging();

      for (int blk = 0; blk < 8; blk++) begin
         case (blk / 2)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 79; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 79; end
            default: begin send_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         if (blk > 0) begin
            settle();
            load_settings(blk);
         end
         test_random_traffic(BLOCK_ITEMS);
      end
      settle();

      if (mismatches == 0)
         $display("thermostat_deadband_controller_core: match");
      else
         $display("thermostat_deadband_controller_core: mismatch");
      $finish;
   end

endmodule

### sim.f
rtl/tdc_pkg.sv
rtl/tdc_cfg_regs.sv
rtl/tdc_state_update.sv
rtl/tdc_average.sv
rtl/tdc_control_out.sv
rtl/thermostat_deadband_controller_core.sv
verif/thermostat_deadband_controller_core_tb.sv
